// ===== rtl/dtsc_pkg.sv =====
// Shared definitions for the decimal token sum and count unit.
// Holds character codes, limits, the control word type and the microprogram ROM.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package dtsc_pkg;

	// Character codes.
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_NUL  = 8'h00;

	// Number format and limits.
	localparam int BIN_W  = 63;
	localparam int CNT_W  = 16;
	localparam int ITER_W = $clog2(BIN_W + 1);
	localparam logic [62:0] NUM_MAX = {1'b0, {62{1'b1}}} | 63'h4000_0000_0000_0000;
	localparam int RESULT_SLOTS = 24;
	localparam logic [15:0] BUF_SIZE_RESET = 16'd256;
	localparam int DEF_MAX_SUM_DIGITS   = 19;
	localparam int DEF_MAX_COUNT_DIGITS = 5;

	// Microprogram step addresses.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] PC_CHAR  = 4'd1;
	localparam logic [PC_W-1:0] PC_CLOSE = 4'd2;
	localparam logic [PC_W-1:0] PC_INIT  = 4'd3;
	localparam logic [PC_W-1:0] PC_CONV  = 4'd4;
	localparam logic [PC_W-1:0] PC_SCAN  = 4'd5;
	localparam logic [PC_W-1:0] PC_FIT   = 4'd6;
	localparam logic [PC_W-1:0] PC_SUM   = 4'd7;
	localparam logic [PC_W-1:0] PC_AMP   = 4'd8;
	localparam logic [PC_W-1:0] PC_CNT   = 4'd9;
	localparam logic [PC_W-1:0] PC_NUL   = 4'd10;

	// Datapath operations.
	localparam logic [3:0] OP_NOP       = 4'd0;
	localparam logic [3:0] OP_LATCH     = 4'd1;
	localparam logic [3:0] OP_CHAR      = 4'd2;
	localparam logic [3:0] OP_CLOSE     = 4'd3;
	localparam logic [3:0] OP_CONV_INIT = 4'd4;
	localparam logic [3:0] OP_CONV      = 4'd5;
	localparam logic [3:0] OP_SCAN      = 4'd6;
	localparam logic [3:0] OP_FIT       = 4'd7;
	localparam logic [3:0] OP_SHIFT_SUM = 4'd8;
	localparam logic [3:0] OP_SHIFT_CNT = 4'd9;
	localparam logic [3:0] OP_CLEAR     = 4'd10;

	// Output character selects.
	localparam logic [2:0] SEL_CH  = 3'd0;
	localparam logic [2:0] SEL_SUM = 3'd1;
	localparam logic [2:0] SEL_AMP = 3'd2;
	localparam logic [2:0] SEL_CNT = 3'd3;
	localparam logic [2:0] SEL_NUL = 3'd4;

	// Jump conditions: taken goes to target, otherwise to the next step.
	localparam logic [2:0] J_NEXT      = 3'd0;
	localparam logic [2:0] J_ALWAYS    = 3'd1;
	localparam logic [2:0] J_IF_END    = 3'd2;
	localparam logic [2:0] J_LOOP_ITER = 3'd3;
	localparam logic [2:0] J_LOOP_SCAN = 3'd4;
	localparam logic [2:0] J_IF_NOFIT  = 3'd5;
	localparam logic [2:0] J_LOOP_NS   = 3'd6;
	localparam logic [2:0] J_LOOP_NC   = 3'd7;

	// One control word per microprogram step.
	typedef struct packed {
		logic [3:0]      op;
		logic            wait_in;
		logic            emit;
		logic            last;
		logic [2:0]      sel;
		logic [2:0]      jc;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// Microprogram ROM.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c = '{op: OP_NOP, wait_in: 1'b0, emit: 1'b0, last: 1'b0, sel: SEL_CH,
			jc: J_ALWAYS, target: PC_IDLE};
		case (pc)
			PC_IDLE: begin
				c.op = OP_LATCH;
				c.wait_in = 1'b1;
				c.jc = J_IF_END;
				c.target = PC_CLOSE;
			end
			PC_CHAR: begin
				c.op = OP_CHAR;
				c.emit = 1'b1;
				c.last = 1'b1;
				c.sel = SEL_CH;
				c.jc = J_ALWAYS;
				c.target = PC_IDLE;
			end
			PC_CLOSE: begin
				c.op = OP_CLOSE;
				c.jc = J_NEXT;
			end
			PC_INIT: begin
				c.op = OP_CONV_INIT;
				c.jc = J_NEXT;
			end
			PC_CONV: begin
				c.op = OP_CONV;
				c.jc = J_LOOP_ITER;
				c.target = PC_CONV;
			end
			PC_SCAN: begin
				c.op = OP_SCAN;
				c.jc = J_LOOP_SCAN;
				c.target = PC_SCAN;
			end
			PC_FIT: begin
				c.op = OP_FIT;
				c.jc = J_IF_NOFIT;
				c.target = PC_NUL;
			end
			PC_SUM: begin
				c.op = OP_SHIFT_SUM;
				c.emit = 1'b1;
				c.sel = SEL_SUM;
				c.jc = J_LOOP_NS;
				c.target = PC_SUM;
			end
			PC_AMP: begin
				c.emit = 1'b1;
				c.sel = SEL_AMP;
				c.jc = J_NEXT;
			end
			PC_CNT: begin
				c.op = OP_SHIFT_CNT;
				c.emit = 1'b1;
				c.sel = SEL_CNT;
				c.jc = J_LOOP_NC;
				c.target = PC_CNT;
			end
			PC_NUL: begin
				c.op = OP_CLEAR;
				c.emit = 1'b1;
				c.last = 1'b1;
				c.sel = SEL_NUL;
				c.jc = J_ALWAYS;
				c.target = PC_IDLE;
			end
			default: begin
				c.jc = J_ALWAYS;
				c.target = PC_IDLE;
			end
		endcase
		return c;
	endfunction

	// Largest value with d decimal digits, limited to cap (elaboration only).
	function automatic logic [63:0] pow10_minus1(input int d, input logic [63:0] cap);
		logic [63:0] v;
		v = 64'd1;
		for (int i = 0; i < 19; i++) begin
			if (i < d) begin
				v = v * 64'd10;
			end
		end
		v = v - 64'd1;
		return (v < cap) ? v : cap;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/decimal_token_sum_count_unit.sv =====
// Top level of the decimal token sum and count unit: a microcoded sequencer
// driving a plain datapath with a binary-to-BCD converter and an output register.
// Depends on dtsc_pkg for codes, limits and the microprogram ROM.
`default_nettype none

//  Channel   Direction  Handshake                  Payload
//  item      in         item_valid/item_stall      cmd, ch
//  result    out        result_valid/result_stall  out_char, suffix_written, overflowed,
//                                                  last_of_run
//  cfg       in         cfg_valid/cfg_ready        cfg_data (buffer_size)
//
// A character item is taken in the idle step, which also computes the next number and
// sum; the character step then commits and loads the output register. An end item is
// taken in the idle step, then come a step to close the last token, a step to load the
// converter, a 63-step binary-to-BCD loop, a leading-zero scan of one step plus one per
// zero skipped in the longer of the two runs, one fit check, then one step per appended
// character.
// Reset clears all string state and sets buffer_size to 256; cfg_ready is always high.
// A stalled result holds the sequencer at its next output step.
module decimal_token_sum_count_unit #(
	parameter int MAX_SUM_DIGITS   = dtsc_pkg::DEF_MAX_SUM_DIGITS,
	parameter int MAX_COUNT_DIGITS = dtsc_pkg::DEF_MAX_COUNT_DIGITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        cmd,
	input  wire logic [7:0]  ch,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       out_char,
	output logic             suffix_written,
	output logic             overflowed,
	output logic             last_of_run,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int SBW = 4 * MAX_SUM_DIGITS;
	localparam int CBW = 4 * MAX_COUNT_DIGITS;
	localparam int NSW = $clog2(MAX_SUM_DIGITS + 1);
	localparam int NCW = $clog2(MAX_COUNT_DIGITS + 1);
	localparam logic [62:0] SUM_CAP =
		63'(dtsc_pkg::pow10_minus1(MAX_SUM_DIGITS, {1'b0, dtsc_pkg::NUM_MAX}));
	localparam logic [15:0] CNT_CAP =
		16'(dtsc_pkg::pow10_minus1(MAX_COUNT_DIGITS, 64'd65535));

	// Sequencer and string state.
	logic [dtsc_pkg::PC_W-1:0] pc_q;
	logic [62:0]               current_q;
	logic [62:0]               sum_q;
	logic [15:0]               tok_q;
	logic [15:0]               len_q;
	logic                      ovf_q;
	logic [15:0]               buf_size_q;
	logic                      out_valid_q;

	// Working registers.
	logic [7:0]                ch_q;
	logic [66:0]               prod_q;
	logic [63:0]               csum_q;
	logic [SBW-1:0]            sbcd_q;
	logic [62:0]               sbin_q;
	logic [CBW-1:0]            cbcd_q;
	logic [15:0]               cbin_q;
	logic [dtsc_pkg::ITER_W-1:0] iter_q;
	logic [NSW-1:0]            ns_q;
	logic [NCW-1:0]            nc_q;
	logic                      fit_q;

	// Output register payload.
	logic [7:0]                out_char_q;
	logic                      sw_q;
	logic                      ovf_out_q;
	logic                      last_q;

	dtsc_pkg::ctrl_t           ctl;
	logic                      item_acc;
	logic                      res_acc;
	logic                      out_free;
	logic                      step_go;
	logic                      emit_go;
	logic                      taken;
	logic [dtsc_pkg::PC_W-1:0] pc_next;
	logic                      is_digit;
	logic [7:0]                in_off;
	logic                      num_sat;
	logic                      csum_over;
	logic                      do_digit;
	logic                      do_close;
	logic                      ovf_upd;
	logic [3:0]                sum_top;
	logic [3:0]                cnt_top;
	logic                      s_shift;
	logic                      c_shift;
	logic                      scan_more;
	logic [17:0]               need_len;
	logic [5:0]                need_slots;
	logic                      fit_now;
	logic [SBW-1:0]            sadj;
	logic [CBW-1:0]            cadj;
	logic [7:0]                emit_char;
	logic                      emit_sw;

	// Control word fetch and handshakes.
	assign ctl        = dtsc_pkg::ucode(pc_q);
	assign item_stall = !ctl.wait_in;
	assign item_acc   = item_valid && !item_stall;
	assign res_acc    = out_valid_q && !result_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign step_go    = ctl.wait_in ? item_acc : (ctl.emit ? out_free : 1'b1);
	assign emit_go    = step_go && ctl.emit;
	assign cfg_ready  = 1'b1;

	// Number and sum arithmetic.
	assign is_digit  = ch_q inside {[dtsc_pkg::CH_ZERO:dtsc_pkg::CH_NINE]};
	assign in_off    = ch - dtsc_pkg::CH_ZERO;
	assign num_sat   = (prod_q[66:63] != 4'd0);
	assign csum_over = (csum_q > {1'b0, SUM_CAP});
	assign do_digit  = step_go && (ctl.op == dtsc_pkg::OP_CHAR) && is_digit;
	assign do_close  = step_go && (current_q != 63'd0) &&
		(((ctl.op == dtsc_pkg::OP_CHAR) && !is_digit) || (ctl.op == dtsc_pkg::OP_CLOSE));
	assign ovf_upd   = ovf_q || (do_digit && num_sat) || (do_close && csum_over);

	// Leading digits and leading-zero scan.
	assign sum_top   = sbcd_q[SBW-1 -: 4];
	assign cnt_top   = cbcd_q[CBW-1 -: 4];
	assign s_shift   = (sum_top == 4'd0) && (ns_q != NSW'(1));
	assign c_shift   = (cnt_top == 4'd0) && (nc_q != NCW'(1));
	assign scan_more = s_shift || c_shift;

	// Fit check: buffer room and result slots.
	assign need_len   = 18'(len_q) + 18'(ns_q) + 18'(nc_q) + 18'd1;
	assign need_slots = 6'(ns_q) + 6'(nc_q) + 6'd2;
	assign fit_now    = (need_len < 18'(buf_size_q)) &&
		(need_slots <= 6'(dtsc_pkg::RESULT_SLOTS));

	// Add-3 correction on every BCD digit before a shift.
	always_comb begin
		for (int i = 0; i < MAX_SUM_DIGITS; i++) begin
			sadj[4*i +: 4] = (sbcd_q[4*i +: 4] >= 4'd5) ? (sbcd_q[4*i +: 4] + 4'd3)
				: sbcd_q[4*i +: 4];
		end
		for (int j = 0; j < MAX_COUNT_DIGITS; j++) begin
			cadj[4*j +: 4] = (cbcd_q[4*j +: 4] >= 4'd5) ? (cbcd_q[4*j +: 4] + 4'd3)
				: cbcd_q[4*j +: 4];
		end
	end

	// Next step address.
	always_comb begin
		case (ctl.jc)
			dtsc_pkg::J_NEXT:      taken = 1'b0;
			dtsc_pkg::J_ALWAYS:    taken = 1'b1;
			dtsc_pkg::J_IF_END:    taken = cmd;
			dtsc_pkg::J_LOOP_ITER: taken = (iter_q != dtsc_pkg::ITER_W'(1));
			dtsc_pkg::J_LOOP_SCAN: taken = scan_more;
			dtsc_pkg::J_IF_NOFIT:  taken = !fit_now;
			dtsc_pkg::J_LOOP_NS:   taken = (ns_q != NSW'(1));
			dtsc_pkg::J_LOOP_NC:   taken = (nc_q != NCW'(1));
			default:               taken = 1'b0;
		endcase
		pc_next = taken ? ctl.target : (pc_q + dtsc_pkg::PC_W'(1));
	end

	// Character that the current step sends out.
	always_comb begin
		case (ctl.sel)
			dtsc_pkg::SEL_CH: begin
				emit_char = ch_q;
				emit_sw   = 1'b0;
			end
			dtsc_pkg::SEL_SUM: begin
				emit_char = dtsc_pkg::CH_ZERO + 8'(sum_top);
				emit_sw   = 1'b1;
			end
			dtsc_pkg::SEL_AMP: begin
				emit_char = dtsc_pkg::CH_AMP;
				emit_sw   = 1'b1;
			end
			dtsc_pkg::SEL_CNT: begin
				emit_char = dtsc_pkg::CH_ZERO + 8'(cnt_top);
				emit_sw   = 1'b1;
			end
			default: begin
				emit_char = dtsc_pkg::CH_NUL;
				emit_sw   = fit_q;
			end
		endcase
	end

	// Sequencer, string state, configuration register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= dtsc_pkg::PC_IDLE;
			current_q   <= '0;
			sum_q       <= '0;
			tok_q       <= '0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			buf_size_q  <= dtsc_pkg::BUF_SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				buf_size_q <= cfg_data;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (res_acc) begin
				out_valid_q <= 1'b0;
			end
			if (step_go) begin
				pc_q  <= pc_next;
				ovf_q <= ovf_upd;
				if (do_digit) begin
					current_q <= num_sat ? dtsc_pkg::NUM_MAX : prod_q[62:0];
				end
				if ((ctl.op == dtsc_pkg::OP_CHAR) && (len_q != 16'hFFFF)) begin
					len_q <= len_q + 16'd1;
				end
				if (do_close) begin
					sum_q     <= csum_over ? SUM_CAP : csum_q[62:0];
					current_q <= '0;
					if (tok_q < CNT_CAP) begin
						tok_q <= tok_q + 16'd1;
					end
				end
				if (ctl.op == dtsc_pkg::OP_CLEAR) begin
					current_q <= '0;
					sum_q     <= '0;
					tok_q     <= '0;
					len_q     <= '0;
					ovf_q     <= 1'b0;
				end
			end
		end
	end

	// Working registers and output payload.
	always_ff @(posedge clk) begin
		if (step_go) begin
			case (ctl.op)
				dtsc_pkg::OP_LATCH: begin
					ch_q   <= ch;
					prod_q <= ({4'd0, current_q} << 3) + ({4'd0, current_q} << 1)
						+ 67'(in_off[3:0]);
					csum_q <= {1'b0, current_q} + {1'b0, sum_q};
				end
				dtsc_pkg::OP_CLOSE: begin
					csum_q <= csum_q;
				end
				dtsc_pkg::OP_CONV_INIT: begin
					sbcd_q <= '0;
					sbin_q <= sum_q;
					cbcd_q <= '0;
					cbin_q <= tok_q;
					iter_q <= dtsc_pkg::ITER_W'(dtsc_pkg::BIN_W);
					ns_q   <= NSW'(MAX_SUM_DIGITS);
					nc_q   <= NCW'(MAX_COUNT_DIGITS);
				end
				dtsc_pkg::OP_CONV: begin
					sbcd_q <= {sadj[SBW-2:0], sbin_q[62]};
					sbin_q <= {sbin_q[61:0], 1'b0};
					if (iter_q <= dtsc_pkg::ITER_W'(dtsc_pkg::CNT_W)) begin
						cbcd_q <= {cadj[CBW-2:0], cbin_q[15]};
						cbin_q <= {cbin_q[14:0], 1'b0};
					end
					iter_q <= iter_q - dtsc_pkg::ITER_W'(1);
				end
				dtsc_pkg::OP_SCAN: begin
					if (s_shift) begin
						sbcd_q <= sbcd_q << 4;
						ns_q   <= ns_q - NSW'(1);
					end
					if (c_shift) begin
						cbcd_q <= cbcd_q << 4;
						nc_q   <= nc_q - NCW'(1);
					end
				end
				dtsc_pkg::OP_FIT: begin
					fit_q <= fit_now;
				end
				dtsc_pkg::OP_SHIFT_SUM: begin
					sbcd_q <= sbcd_q << 4;
					ns_q   <= ns_q - NSW'(1);
				end
				dtsc_pkg::OP_SHIFT_CNT: begin
					cbcd_q <= cbcd_q << 4;
					nc_q   <= nc_q - NCW'(1);
				end
				default: begin
					fit_q <= fit_q;
				end
			endcase
		end
		if (emit_go) begin
			out_char_q <= emit_char;
			sw_q       <= emit_sw;
			ovf_out_q  <= ovf_upd;
			last_q     <= ctl.last;
		end
	end

	assign result_valid   = out_valid_q;
	assign out_char       = out_char_q;
	assign suffix_written = sw_q;
	assign overflowed     = ovf_out_q;
	assign last_of_run    = last_q;

	// An accepted item always moves the sequencer out of the idle step.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> (pc_q == dtsc_pkg::PC_CHAR || pc_q == dtsc_pkg::PC_CLOSE))
		else $error("sequencer did not leave idle after an accepted item");

	// The leading-zero scan leaves a nonzero top digit unless one digit remains.
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == dtsc_pkg::PC_FIT) |-> (ns_q == NSW'(1) || sum_top != 4'd0))
		else $error("sum digits still carry a leading zero after the scan");

	// The running sum never exceeds its saturation limit.
	a_sum_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_CAP)
		else $error("running sum above its limit");

	// The token count never exceeds its saturation limit.
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q <= CNT_CAP)
		else $error("token count above its limit");

	// A digit emission step never runs with an empty digit counter.
	a_digit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == dtsc_pkg::PC_SUM) |-> (ns_q != NSW'(0)))
		else $error("sum digit emitted with no digits left");

endmodule

`default_nettype wire

// ===== tb/sv/decimal_token_sum_count_checker.sv =====
// Scoreboard for the decimal token sum and count unit: watches the item, result and
// configuration channels, predicts every output character and compares it field by field.
// Depends on dtsc_pkg for character codes, limits and the buffer size reset value.
module decimal_token_sum_count_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic        item_stall,
	input  wire logic        cmd,
	input  wire logic [7:0]  ch,
	input  wire logic        result_valid,
	input  wire logic        result_stall,
	input  wire logic [7:0]  out_char,
	input  wire logic        suffix_written,
	input  wire logic        overflowed,
	input  wire logic        last_of_run,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [15:0] cfg_data,
	output int               mismatch_count,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// With the default digit limits, 10^19-1 is above 2^63-1 and 10^5-1 is above
	// 65535, so the type limits are the effective ceilings.
	localparam logic [63:0] SUM_CEILING   = {1'b0, dtsc_pkg::NUM_MAX};
	localparam logic [15:0] COUNT_CEILING = 16'hFFFF;

	// One output character with its flags.
	typedef struct packed {
		logic [7:0] out_char;
		logic       suffix_written;
		logic       overflowed;
		logic       last_of_run;
	} emitted_char_t;

	// Per-string state of the prediction and the buffer size register.
	logic [62:0]   number_acc;
	logic [62:0]   sum_acc;
	logic [15:0]   token_total;
	logic [15:0]   text_length;
	logic          saturated;
	logic [15:0]   buffer_size;
	emitted_char_t expected_chars[$];

	task automatic push_char(input logic [7:0] value, input logic in_suffix,
			input logic final_one);
		emitted_char_t entry;
		entry.out_char = value;
		entry.suffix_written = in_suffix;
		entry.overflowed = saturated;
		entry.last_of_run = final_one;
		expected_chars.push_back(entry);
	endtask

	task automatic clear_text();
		number_acc = '0;
		sum_acc = '0;
		token_total = '0;
		text_length = '0;
		saturated = 1'b0;
	endtask

	// A finished nonzero number goes into the sum and the token count.
	task automatic close_token();
		logic [63:0] total;
		if (number_acc != '0) begin
			total = {1'b0, sum_acc} + {1'b0, number_acc};
			if (total > SUM_CEILING) begin
				total = SUM_CEILING;
				saturated = 1'b1;
			end
			sum_acc = total[62:0];
			if (token_total < COUNT_CEILING) begin
				token_total++;
			end
			number_acc = '0;
		end
	endtask

	// A string character: digits extend the current number, anything else ends it.
	task automatic take_char(input logic [7:0] value);
		logic [63:0] digit;
		logic [63:0] grown;
		if (value >= dtsc_pkg::CH_ZERO && value <= dtsc_pkg::CH_NINE) begin
			digit = {56'd0, value - dtsc_pkg::CH_ZERO};
			if ({1'b0, number_acc} > ({1'b0, dtsc_pkg::NUM_MAX} - digit) / 64'd10) begin
				number_acc = dtsc_pkg::NUM_MAX;
				saturated = 1'b1;
			end else begin
				grown = {1'b0, number_acc} * 64'd10 + digit;
				number_acc = grown[62:0];
			end
		end else begin
			close_token();
		end
		if (text_length != 16'hFFFF) begin
			text_length++;
		end
		push_char(value, 1'b0, 1'b1);
	endtask

	// End of string: the sum, an ampersand, the count and a terminator if they fit,
	// otherwise the terminator alone.
	task automatic finish_text();
		string sum_text;
		string count_text;
		int    i;
		close_token();
		sum_text = $sformatf("%0d", sum_acc);
		count_text = $sformatf("%0d", token_total);
		if (int'(text_length) + sum_text.len() + count_text.len() + 1 >= int'(buffer_size)
				|| sum_text.len() + count_text.len() + 2 > dtsc_pkg::RESULT_SLOTS) begin
			push_char(dtsc_pkg::CH_NUL, 1'b0, 1'b1);
		end else begin
			for (i = 0; i < sum_text.len(); i++) begin
				push_char(sum_text[i], 1'b1, 1'b0);
			end
			push_char(dtsc_pkg::CH_AMP, 1'b1, 1'b0);
			for (i = 0; i < count_text.len(); i++) begin
				push_char(count_text[i], 1'b1, 1'b0);
			end
			push_char(dtsc_pkg::CH_NUL, 1'b1, 1'b1);
		end
		clear_text();
	endtask

	task automatic report_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		mismatch_count++;
		$error("%s: expected %0h, got %0h", field, want, got);
	endtask

	// Compare one accepted result transaction with the oldest expectation.
	task automatic check_result();
		emitted_char_t want;
		if (expected_chars.size() == 0) begin
			mismatch_count++;
			$error("out_char: expected no transaction, got %0h", out_char);
		end else begin
			want = expected_chars.pop_front();
			if (out_char !== want.out_char) begin
				report_field("out_char", want.out_char, out_char);
			end
			if (suffix_written !== want.suffix_written) begin
				report_field("suffix_written", want.suffix_written, suffix_written);
			end
			if (overflowed !== want.overflowed) begin
				report_field("overflowed", want.overflowed, overflowed);
			end
			if (last_of_run !== want.last_of_run) begin
				report_field("last_of_run", want.last_of_run, last_of_run);
			end
		end
	endtask

	// Channel monitor: results, register writes and items at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_text();
			buffer_size = dtsc_pkg::BUF_SIZE_RESET;
			expected_chars.delete();
			mismatch_count = 0;
		end else begin
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				check_result();
			end
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
				buffer_size = cfg_data;
			end
			if (item_valid === 1'b1 && item_stall === 1'b0) begin
				if (cmd) begin
					finish_text();
				end else begin
					take_char(ch);
				end
			end
		end
		outstanding = expected_chars.size();
	end

endmodule

// ===== tb/sv/decimal_token_sum_count_unit_test.sv =====
// Top of the decimal token sum and count unit testbench: clock, reset, item stimulus,
// result back-pressure and buffer size writes, with the verdict at the end.
// Depends on dtsc_pkg, the unit and decimal_token_sum_count_checker.
module decimal_token_sum_count_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD        = 6;
	localparam int RESET_CYCLES       = 9;
	localparam int CYCLE_LIMIT        = 1000000;
	localparam int RANDOM_ITEMS       = 215;
	localparam int IDLE_PERCENT       = 10;
	localparam int HOLD_CYCLES        = 300;
	localparam int SETTLE_CYCLES      = 8;
	localparam int TAIL_CYCLES        = 150;

	typedef enum int {TOKEN_SHORT, TOKEN_ZEROS, TOKEN_HUGE} token_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        cmd = 1'b0;
	logic [7:0]  ch = 8'h00;
	logic        result_stall = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [15:0] cfg_data = 16'h0000;
	logic        item_stall;
	logic        result_valid;
	logic [7:0]  out_char;
	logic        suffix_written;
	logic        overflowed;
	logic        last_of_run;
	logic        cfg_ready;

	int          mismatch_count;
	int          outstanding;
	int          items_sent = 0;
	int unsigned cycle_count = 0;
	bit          sender_idles = 1'b0;
	bit          receiver_idles = 1'b0;
	bit          hold_request = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	decimal_token_sum_count_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.cmd            (cmd),
		.ch             (ch),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_char       (out_char),
		.suffix_written (suffix_written),
		.overflowed     (overflowed),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	decimal_token_sum_count_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.cmd            (cmd),
		.ch             (ch),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_char       (out_char),
		.suffix_written (suffix_written),
		.overflowed     (overflowed),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stalls, or one long hold when the stimulus asks for it.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					result_stall <= 1'b1;
					@(negedge clk);
				end
			end
			result_stall <= receiver_idles && ($urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Offer one item and wait for its transaction, sometimes after an idle gap.
	task automatic send_item(input logic is_end, input logic [7:0] value);
		int gap;
		if (sender_idles && $urandom_range(0, 99) < IDLE_PERCENT) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				item_valid <= 1'b0;
			end
		end
		@(negedge clk);
		item_valid <= 1'b1;
		cmd <= is_end;
		ch <= value;
		do @(posedge clk); while (item_stall !== 1'b0);
		items_sent++;
	endtask

	task automatic send_text(input string text);
		int i;
		for (i = 0; i < text.len(); i++) begin
			send_item(1'b0, text[i]);
		end
	endtask

	function automatic logic [7:0] any_separator();
		logic [7:0] value;
		value = 8'($urandom_range(0, 255));
		while (value >= dtsc_pkg::CH_ZERO && value <= dtsc_pkg::CH_NINE) begin
			value = 8'($urandom_range(0, 255));
		end
		return value;
	endfunction

	// Digit runs: short numbers, all-zero runs, and long numbers of 18 to 20 digits, some past saturation.
	task automatic send_token(input token_kind_t kind);
		int n;
		case (kind)
			TOKEN_SHORT: begin
				n = $urandom_range(1, 4);
				repeat (n) send_item(1'b0, dtsc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
			end
			TOKEN_ZEROS: begin
				n = $urandom_range(1, 3);
				repeat (n) send_item(1'b0, dtsc_pkg::CH_ZERO);
			end
			default: begin
				n = $urandom_range(18, 20);
				send_item(1'b0, dtsc_pkg::CH_NINE);
				repeat (n - 1) send_item(1'b0, dtsc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
			end
		endcase
	endtask

	// One string: mostly tokens between separators, sometimes raw noise bytes.
	task automatic send_random_text();
		int          tokens;
		int          i;
		int          n;
		int          r;
		token_kind_t kind;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			n = $urandom_range(1, 20);
			repeat (n) send_item(1'b0, 8'($urandom_range(0, 255)));
		end else begin
			tokens = $urandom_range(0, 4);
			if ($urandom_range(0, 1) == 1) begin
				send_item(1'b0, any_separator());
			end
			for (i = 0; i < tokens; i++) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					kind = TOKEN_SHORT;
				end else if (r < 80) begin
					kind = TOKEN_ZEROS;
				end else begin
					kind = TOKEN_HUGE;
				end
				send_token(kind);
				if (i < tokens - 1 || $urandom_range(0, 1) == 1) begin
					n = $urandom_range(1, 2);
					repeat (n) send_item(1'b0, any_separator());
				end
			end
		end
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// Stop offering items and wait until every expected character has come out.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_buffer_size(input logic [15:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Main stimulus.
	initial begin
		int first_random;
		int texts;
		int r;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;

		// Reset buffer size: leading zeros, digit neighbors, a NUL byte, a trailing
		// zero run closed by the end item, then an empty string.
		send_text("007/12:");
		send_item(1'b0, dtsc_pkg::CH_NUL);
		send_text("9");
		send_item(1'b0, 8'hFF);
		send_text("0");
		send_item(1'b1, 8'h00);
		send_item(1'b1, 8'hA5);

		// Buffer one short of the suffix, exactly enough, and the smallest nonzero size.
		write_buffer_size(16'd4);
		send_text("5");
		send_item(1'b1, 8'h00);
		write_buffer_size(16'd5);
		send_text("5");
		send_item(1'b1, 8'h00);
		write_buffer_size(16'd1);
		send_text("3");
		send_item(1'b1, 8'h00);

		// Random strings with buffer sizes changed between them.
		write_buffer_size(16'hFFFF);
		first_random = items_sent;
		texts = 0;
		while (items_sent - first_random < RANDOM_ITEMS) begin
			if (texts % 6 == 5) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					write_buffer_size(16'($urandom_range(1, 48)));
				end else if (r < 55) begin
					write_buffer_size(16'd1);
				end else if (r < 65) begin
					write_buffer_size(16'hFFFF);
				end else begin
					write_buffer_size(16'($urandom_range(1, 65535)));
				end
			end
			if (texts == 3) begin
				hold_request = 1'b1;
			end
			send_random_text();
			texts++;
		end

		// Long stretch without idling. The sum saturates at its ceiling, so the
		// longest sum is appended with the overflow flag set.
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		write_buffer_size(16'hFFFF);
		send_text("9223372036854775807+12");
		send_item(1'b1, 8'hFF);

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dtsc_pkg.sv
rtl/decimal_token_sum_count_unit.sv
tb/sv/decimal_token_sum_count_checker.sv
tb/sv/decimal_token_sum_count_unit_test.sv
